[rtl/des_pkg.sv]
// DES package: permutation tables, S-boxes, round-key and round functions.
`timescale 1ns / 1ps
package des_pkg;

  localparam int unsigned BlockW  = 64;
  localparam int unsigned KeyW    = 48;
  localparam int unsigned NRounds = 16;
  localparam int unsigned HalfKW  = 28;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned ModeW   = 2;

  localparam logic [CfgIdxW-1:0] CfgKey  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMode = 1'b1;

  typedef enum logic [ModeW-1:0] {
    ModeEnc  = 2'd0,
    ModeDec  = 2'd1,
    ModeNone = 2'd2,
    ModeRsvd = 2'd3
  } mode_e;

  typedef logic [KeyW-1:0] rkey_t;

  typedef struct packed {
    logic [31:0] l;
    logic [31:0] r;
    logic        last;
  } blk_t;

  localparam logic [7:0] TabIp [64] = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};

  localparam logic [7:0] TabFp [64] = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};

  localparam logic [7:0] TabE [48] = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};

  localparam logic [7:0] TabP [32] = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25};

  localparam logic [7:0] TabPc1 [56] = '{
    57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
    10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
    63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
    14,6,61,53,45,37,29, 21,13,5,28,20,12,4};

  localparam logic [7:0] TabPc2 [48] = '{
    14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
    41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};

  localparam logic [1:0] RotSched [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

  localparam logic [3:0] Sbox [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  // Tables count bits from 1 at the top of the word.
  function automatic logic [63:0] ip_perm(input logic [63:0] x);
    logic [63:0] y;
    for (int i = 0; i < 64; i++) y[63-i] = x[64 - int'(TabIp[i])];
    return y;
  endfunction

  function automatic logic [63:0] fp_perm(input logic [63:0] x);
    logic [63:0] y;
    for (int i = 0; i < 64; i++) y[63-i] = x[64 - int'(TabFp[i])];
    return y;
  endfunction

  function automatic logic [55:0] pc1_perm(input logic [63:0] x);
    logic [55:0] y;
    for (int i = 0; i < 56; i++) y[55-i] = x[64 - int'(TabPc1[i])];
    return y;
  endfunction

  function automatic rkey_t pc2_perm(input logic [55:0] x);
    rkey_t y;
    for (int i = 0; i < 48; i++) y[47-i] = x[56 - int'(TabPc2[i])];
    return y;
  endfunction

  function automatic logic [HalfKW-1:0] rotl28(input logic [HalfKW-1:0] x,
                                               input logic [1:0] s);
    return (s == 2'd1) ? {x[HalfKW-2:0], x[HalfKW-1]} : {x[HalfKW-3:0], x[HalfKW-1 -: 2]};
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] r, input rkey_t k);
    logic [47:0] x;
    logic [31:0] s;
    logic [5:0]  b;
    logic [31:0] y;
    for (int i = 0; i < 48; i++) x[47-i] = r[32 - int'(TabE[i])];
    x = x ^ k;
    for (int i = 0; i < 8; i++) begin
      b = x[47-6*i -: 6];
      s[31-4*i -: 4] = Sbox[i][{b[5], b[0], b[4:1]}];
    end
    for (int i = 0; i < 32; i++) y[31-i] = s[32 - int'(TabP[i])];
    return y;
  endfunction

endpackage

[rtl/des_stream_if.sv]
// Valid/ready stream interface carrying one DES block item.
`timescale 1ns / 1ps
interface des_stream_if;
  logic        valid;
  logic        ready;
  logic [63:0] block;
  logic        last;
  modport source (output valid, output block, output last, input ready);
  modport sink   (input valid, input block, input last, output ready);
endinterface

[rtl/des_key_sched.sv]
// DES key schedule: registered 16 round keys, ordered by mode.
`timescale 1ns / 1ps
module des_key_sched (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [63:0]                key_i,
  input  logic [des_pkg::ModeW-1:0]  mode_i,
  output des_pkg::rkey_t             rkey_o [des_pkg::NRounds],
  output logic                       bypass_o
);
  des_pkg::rkey_t rk [des_pkg::NRounds];
  des_pkg::rkey_t rkey_q [des_pkg::NRounds];
  logic bypass_q;

  always_comb begin
    logic [55:0] cd;
    logic [27:0] c, d;
    cd = des_pkg::pc1_perm(key_i);
    c  = cd[55:28];
    d  = cd[27:0];
    for (int i = 0; i < des_pkg::NRounds; i++) begin
      c = des_pkg::rotl28(c, des_pkg::RotSched[i]);
      d = des_pkg::rotl28(d, des_pkg::RotSched[i]);
      rk[i] = des_pkg::pc2_perm({c, d});
    end
  end

  // User keeps config static while items flow (block does not enforce it); one register level decouples the schedule.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bypass_q <= 1'b0;
    end else begin
      bypass_q <= !(mode_i == des_pkg::ModeEnc || mode_i == des_pkg::ModeDec);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < des_pkg::NRounds; i++)
      rkey_q[i] <= (mode_i == des_pkg::ModeDec) ? rk[des_pkg::NRounds-1-i] : rk[i];
  end

  assign rkey_o   = rkey_q;
  assign bypass_o = bypass_q;
endmodule

[rtl/des_round.sv]
// One Feistel round stage (pass-through in bypass) with valid bit and stall hold.
`timescale 1ns / 1ps
module des_round (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  des_pkg::blk_t  blk_i,
  input  des_pkg::rkey_t rkey_i,
  input  logic           bypass_i,
  output logic           valid_o,
  output des_pkg::blk_t  blk_o
);
  logic          valid_q;
  des_pkg::blk_t blk_q, blk_d;

  always_comb begin
    blk_d = blk_i;
    if (!bypass_i) begin
      blk_d.l = blk_i.r;
      blk_d.r = blk_i.l ^ des_pkg::feistel(blk_i.r, rkey_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) blk_q <= blk_d;
  end

  assign valid_o = valid_q;
  assign blk_o   = blk_q;
endmodule

[rtl/des_ecb_block_cipher.sv]
// DES ECB top level: config registers, IP, 16 round stages, FP output register.
// Path from input accept to output valid: IP stage, 16 round stages, FP stage registers.
// Throughput: one item per cycle while the output is not stalled; each Feistel round is one pipeline stage.
// The whole pipe advances together; it moves whenever the output register is empty or being taken.
// Reset: asynchronous active-low; clears valid bits, key to zero and mode to encrypt.
`timescale 1ns / 1ps
module des_ecb_block_cipher (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  des_stream_if.sink                    in_i,
  des_stream_if.source                  out_o,
  input  logic                          cfg_we_i,
  input  logic [des_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [des_pkg::CfgDataW-1:0]  cfg_data_i
);
  localparam int unsigned N = des_pkg::NRounds;

  logic [63:0]               key_q;
  logic [des_pkg::ModeW-1:0] mode_q;
  des_pkg::rkey_t            rkey [N];
  logic                      bypass;

  logic          en;
  logic          v [N+1];
  des_pkg::blk_t b [N+1];
  logic          in_v_q;
  des_pkg::blk_t in_b_q;
  logic          out_v_q;
  logic [63:0]   out_blk_q;
  logic          out_last_q;
  logic [63:0]   ip_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= '0;
      mode_q <= des_pkg::ModeEnc;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        des_pkg::CfgKey:  key_q  <= cfg_data_i;
        des_pkg::CfgMode: mode_q <= cfg_data_i[des_pkg::ModeW-1:0];
        default: ;
      endcase
    end
  end

  des_key_sched u_ks (
    .clk_i, .rst_ni, .key_i(key_q), .mode_i(mode_q), .rkey_o(rkey), .bypass_o(bypass)
  );

  assign en       = !out_v_q || out_o.ready;
  assign in_i.ready = en;

  assign ip_w = des_pkg::ip_perm(in_i.block);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (en) begin
      in_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) in_b_q <= '{l: ip_w[63:32], r: ip_w[31:0], last: in_i.last};
  end

  assign v[0] = in_v_q;
  assign b[0] = in_b_q;

  for (genvar g = 0; g < N; g++) begin : g_rnd
    des_round u_rnd (
      .clk_i, .rst_ni, .en_i(en), .valid_i(v[g]), .blk_i(b[g]), .rkey_i(rkey[g]),
      .bypass_i(bypass), .valid_o(v[g+1]), .blk_o(b[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= v[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_blk_q  <= des_pkg::fp_perm({b[N].r, b[N].l});
      out_last_q <= b[N].last;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.block = out_blk_q;
  assign out_o.last  = out_last_q;

  // Input is taken exactly when the pipe advances.
  a_ready_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready == (!out_o.valid || out_o.ready))
    else $error("ready does not follow pipe advance");

  // A stalled pipe keeps its last-stage valid.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> ($stable(v[N]) && out_o.valid))
    else $error("stage lost during stall");

  // An accepted item is held in the IP stage register ahead of the first round.
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> v[0])
    else $error("accepted item missing in pipe");
endmodule

[dv/tb_top.sv]
// Self-checking testbench for the DES ECB cipher: directed vectors, random blocks, back-pressure.
`timescale 1ns / 1ps
module tb_top;

  typedef struct packed {
    logic [63:0] block;
    logic        last;
  } cipher_out_t;

  localparam int HoldCycles = 80;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [des_pkg::CfgIdxW-1:0] cfg_idx_i = des_pkg::CfgKey;
  logic [des_pkg::CfgDataW-1:0] cfg_data_i = '0;

  des_stream_if in_if ();
  des_stream_if out_if ();

  des_ecb_block_cipher uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  logic [63:0] key_shadow = '0;
  des_pkg::mode_e mode_shadow = des_pkg::ModeEnc;
  cipher_out_t expected_q[$];
  int errors = 0;
  bit idle_en = 1'b1;
  bit hold_go = 1'b0;

  // Our own DES: key schedule, sixteen Feistel rounds (encrypt and decrypt modes only), IP/FP.
  function automatic logic [63:0] des_transform(input logic [63:0] blk,
                                                input logic [63:0] key,
                                                input des_pkg::mode_e mode);
    logic [55:0] cd;
    logic [27:0] c, d;
    logic [55:0] cdr;
    logic [47:0] sub_keys [16];
    logic [63:0] p, q;
    logic [31:0] lh, rh, t, s, f;
    logic [47:0] x;
    logic [5:0]  b;
    for (int i = 0; i < 56; i++) cd[55-i] = key[64 - int'(des_pkg::TabPc1[i])];
    c = cd[55:28];
    d = cd[27:0];
    for (int r = 0; r < 16; r++) begin
      for (int k = 0; k < int'(des_pkg::RotSched[r]); k++) begin
        c = {c[26:0], c[27]};
        d = {d[26:0], d[27]};
      end
      cdr = {c, d};
      for (int j = 0; j < 48; j++) sub_keys[r][47-j] = cdr[56 - int'(des_pkg::TabPc2[j])];
    end
    for (int i = 0; i < 64; i++) p[63-i] = blk[64 - int'(des_pkg::TabIp[i])];
    lh = p[63:32];
    rh = p[31:0];
    if (mode == des_pkg::ModeEnc || mode == des_pkg::ModeDec) begin
      for (int r = 0; r < 16; r++) begin
        for (int j = 0; j < 48; j++) x[47-j] = rh[32 - int'(des_pkg::TabE[j])];
        x = x ^ sub_keys[(mode == des_pkg::ModeEnc) ? r : 15 - r];
        for (int j = 0; j < 8; j++) begin
          b = x[47-6*j -: 6];
          s[31-4*j -: 4] = des_pkg::Sbox[j][int'({b[5], b[0]}) * 16 + int'(b[4:1])];
        end
        for (int j = 0; j < 32; j++) f[31-j] = s[32 - int'(des_pkg::TabP[j])];
        t = rh;
        rh = lh ^ f;
        lh = t;
      end
    end
    p = {rh, lh};
    for (int i = 0; i < 64; i++) q[63-i] = p[64 - int'(des_pkg::TabFp[i])];
    return q;
  endfunction

  task automatic write_reg(input logic [des_pkg::CfgIdxW-1:0] idx, input logic [63:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == des_pkg::CfgKey) key_shadow = data;
    else mode_shadow = des_pkg::mode_e'(data[des_pkg::ModeW-1:0]);
  endtask

  task automatic send_block(input logic [63:0] blk, input logic last);
    int gap;
    @(negedge clk_i);
    in_if.valid <= 1'b1;
    in_if.block <= blk;
    in_if.last  <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    expected_q.push_back('{des_transform(blk, key_shadow, mode_shadow), last});
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Lower valid, then wait until all expected results are checked and let the pipe settle.
  task automatic drain_pipe();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (24) @(posedge clk_i);
  endtask

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    int stall;
    bit hold_taken;
    stall = 0;
    hold_taken = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        @(negedge clk_i);
        out_if.ready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        out_if.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(0, 3);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cipher_out_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected item block=%h last=%b", $time, out_if.block, out_if.last);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (out_if.block !== want.block) begin
          $display("%0t: block mismatch expected %h actual %h", $time, want.block,
                   out_if.block);
          errors++;
        end
        if (out_if.last !== want.last) begin
          $display("%0t: last mismatch expected %b actual %b", $time, want.last,
                   out_if.last);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    // reset values: key zero, encrypt
    send_block(64'h0, 1'b0);
    send_block(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    drain_pipe();
    write_reg(des_pkg::CfgKey, 64'h1334_5779_9BBC_DFF1);
    send_block(64'h0123_4567_89AB_CDEF, 1'b1);
    send_block(64'h8000_0000_0000_0001, 1'b0);
    drain_pipe();
    write_reg(des_pkg::CfgMode, 64'(des_pkg::ModeDec));
    send_block(64'h85E8_1354_0F0A_B405, 1'b1);
    send_block(64'h0, 1'b0);
    drain_pipe();
    write_reg(des_pkg::CfgKey, 64'hFFFF_FFFF_FFFF_FFFF);
    send_block(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_block(64'h0, 1'b0);
    drain_pipe();
    // parity bits only: same round keys as key zero
    write_reg(des_pkg::CfgKey, 64'h0101_0101_0101_0101);
    write_reg(des_pkg::CfgMode, 64'(des_pkg::ModeEnc));
    send_block(64'hA5A5_5A5A_0F0F_F0F0, 1'b0);
    drain_pipe();
    write_reg(des_pkg::CfgMode, 64'(des_pkg::ModeNone));
    send_block(64'h0123_4567_89AB_CDEF, 1'b1);
    send_block(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    drain_pipe();
    write_reg(des_pkg::CfgMode, 64'(des_pkg::ModeRsvd));
    send_block(64'h0123_4567_89AB_CDEF, 1'b0);
    send_block(64'h0, 1'b1);
    drain_pipe();
  endtask

  task automatic test_random_phase(input des_pkg::mode_e mode, input logic [63:0] key,
                                   input int n);
    write_reg(des_pkg::CfgKey, key);
    write_reg(des_pkg::CfgMode, 64'(mode));
    for (int i = 0; i < n; i++)
      send_block({$urandom, $urandom}, ($urandom_range(0, 7) == 0));
    drain_pipe();
  endtask

  task automatic test_backpressure();
    write_reg(des_pkg::CfgKey, {$urandom, $urandom});
    write_reg(des_pkg::CfgMode, 64'(des_pkg::ModeEnc));
    hold_go = 1'b1;
    for (int i = 0; i < 40; i++) send_block({$urandom, $urandom}, i[0]);
    drain_pipe();
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.block = '0;
    in_if.last  = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random_phase(des_pkg::ModeEnc, {$urandom, $urandom}, 180);
    test_random_phase(des_pkg::ModeDec, 64'hFFFF_FFFF_FFFF_FFFF, 150);
    test_random_phase(des_pkg::ModeNone, {$urandom, $urandom}, 100);
    test_backpressure();
    test_random_phase(des_pkg::ModeRsvd, 64'h0, 80);
    test_random_phase(des_pkg::ModeDec, {$urandom, $urandom}, 150);
    idle_en = 1'b0;
    test_random_phase(des_pkg::ModeEnc, {$urandom, $urandom}, 130);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
